/* hdl/rsp_pkg.sv */
// Package with the payload types, codes and state type of the slot pool.
`timescale 1ns / 1ps

package rsp_pkg;

  // Operation codes carried in the request.
  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_ADD_REF = 2'd1,
    OP_RELEASE = 2'd2
  } rsp_op_t;

  // Status codes carried in the response.
  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_POOL_FULL = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_DUPLICATE = 3'd3,
    STATUS_OVERFLOW  = 3'd4
  } rsp_status_t;

  localparam int ACTIVE_W = 7;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] slot_index;
  } rsp_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  granted_slot;
    logic [7:0]  ref_count;
    logic        freed;
    logic [31:0] reserve_total;
    logic [31:0] release_total;
    logic [31:0] peak_in_use;
  } rsp_resp_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } rsp_state_t;

endpackage

/* hdl/rsp_if.sv */
// Valid/ready channel interfaces for requests, responses and configuration writes.
`timescale 1ns / 1ps

interface rsp_in_if;
  logic               valid;
  logic               ready;
  rsp_pkg::rsp_req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsp_out_if;
  logic               valid;
  logic               ready;
  rsp_pkg::rsp_resp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rsp_pkg::ACTIVE_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/refcounted_slot_pool.sv */
// Top level of the reference-counted slot pool: count memory, free search and totals.
`timescale 1ns / 1ps

// The pool hands out slot indices and keeps a reference count for each slot.
// Requests arrive on req (reserve, add reference, release); each request
// transaction produces exactly one response transaction on res carrying the
// status, the slot, its count after the operation and the three running totals.
// The cfg channel writes the number of active slots; it is always ready and
// should only be used while no request is in flight.
// In the accept cycle the lowest free active slot is picked from the
// nonzero-count flags and the count memory is read; in the exec state
// that follows, the count is modified and written back and the response
// register is loaded once res can take it. Because of the count memory
// read/modify/write, a new request is accepted only once the last is done.
// When res stalls, the finished response waits in its output register; one
// more request may be accepted behind it, and it holds in the exec state
// until the register frees up.
// Reset clears the nonzero-count flags (every slot reads as free), the totals
// and the output register, and sets active slots to 64. The count memory is
// not cleared: a slot whose flag is clear reads as zero, so no clearing pass
// is needed and the block is ready as soon as reset is released.
module refcounted_slot_pool #(
  parameter int SLOTS    = 64,
  parameter int REF_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  rsp_in_if.sink            req,
  rsp_out_if.source         res,
  rsp_cfg_if.sink           cfg
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int LIM_W = $clog2(SLOTS + 1);
  localparam int CW    = (LIM_W > rsp_pkg::ACTIVE_W) ? LIM_W : rsp_pkg::ACTIVE_W;
  localparam int CE_W  = (REF_BITS > 8) ? REF_BITS : 8;
  localparam int SE_W  = (IDX_W > 6) ? IDX_W : 6;

  // Configuration and running totals.
  logic [rsp_pkg::ACTIVE_W-1:0] active_slots;
  logic [31:0]                  reserves_done;
  logic [31:0]                  releases_done;
  logic [31:0]                  peak_seen;

  // One flag per slot, set while its count is nonzero.
  logic [SLOTS-1:0]             nz;

  // Count memory with a registered read port.
  logic [REF_BITS-1:0]          mem [SLOTS];
  logic [REF_BITS-1:0]          rdata;
  logic [IDX_W-1:0]             rd_addr;
  logic                         mem_we;
  logic [REF_BITS-1:0]          wdata;

  // Request held for the modify step.
  rsp_pkg::rsp_state_t          state;
  rsp_pkg::rsp_state_t          state_next;
  logic [1:0]                   op;
  logic [IDX_W-1:0]             addr;
  logic                         hit;

  logic                         req_fire;
  logic                         exec_go;

  // Active limit, clamped to the pool size.
  logic [CW-1:0]                act_ext;
  logic [CW-1:0]                lim;
  logic [CW-1:0]                idx_ext;
  logic                         idx_ok;

  // Lowest free slot search.
  logic [SLOTS-1:0]             free_vec;
  logic [IDX_W-1:0]             pick;
  logic                         found;

  // Modify-step results.
  logic [REF_BITS-1:0]          cnt_cur;
  logic [REF_BITS-1:0]          cnt_out;
  logic [2:0]                   st_out;
  logic [IDX_W-1:0]             slot_out;
  logic                         freed_out;
  logic                         nz_set;
  logic                         nz_clr;
  logic                         bump_res;
  logic                         bump_rel;
  logic [31:0]                  reserves_next;
  logic [31:0]                  releases_next;
  logic [31:0]                  peak_next;
  logic [31:0]                  delta;
  logic [CE_W-1:0]              cnt_ext;
  logic [SE_W-1:0]              slot_ext;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= rsp_pkg::ACTIVE_RESET;
    end else if (cfg.valid) begin
      active_slots <= cfg.data;
    end
  end

  always_comb begin
    act_ext = CW'(active_slots);
    lim     = (act_ext > CW'(SLOTS)) ? CW'(SLOTS) : act_ext;
    idx_ext = CW'(req.data.slot_index);
    idx_ok  = idx_ext < lim;
  end

  // A slot is free when its count is zero and it lies below the active limit.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_vec[i] = !nz[i] && (CW'(i) < lim);
    end
  end

  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        pick  = IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rsp_pkg::ST_IDLE: begin
        if (req.valid) state_next = rsp_pkg::ST_EXEC;
      end
      rsp_pkg::ST_EXEC: begin
        if (exec_go) state_next = rsp_pkg::ST_IDLE;
      end
      default: state_next = rsp_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory address control.
  always_comb begin
    req.ready = 1'b0;
    exec_go   = 1'b0;
    rd_addr   = addr;
    case (state)
      rsp_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        rd_addr   = (req.data.op == rsp_pkg::OP_RESERVE) ? pick : idx_ext[IDX_W-1:0];
      end
      rsp_pkg::ST_EXEC: begin
        exec_go = !res.valid || res.ready;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign req_fire = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture; hit means a free slot was found for a reserve or the
  // index is in range for the other operations.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op   <= req.data.op;
      addr <= rd_addr;
      hit  <= (req.data.op == rsp_pkg::OP_RESERVE) ? found : idx_ok;
    end
  end

  // The held address is re-read while the response stalls; nothing writes
  // it in that time, so the data stays the same.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // Modify step.
  always_comb begin
    cnt_cur   = nz[addr] ? rdata : '0;
    cnt_out   = '0;
    st_out    = rsp_pkg::STATUS_NOT_FOUND;
    slot_out  = '0;
    freed_out = 1'b0;
    mem_we    = 1'b0;
    wdata     = '0;
    nz_set    = 1'b0;
    nz_clr    = 1'b0;
    bump_res  = 1'b0;
    bump_rel  = 1'b0;
    case (op)
      rsp_pkg::OP_RESERVE: begin
        if (hit) begin
          st_out   = rsp_pkg::STATUS_OK;
          slot_out = addr;
          cnt_out  = REF_BITS'(1);
          wdata    = REF_BITS'(1);
          mem_we   = exec_go;
          nz_set   = exec_go;
          bump_res = exec_go;
        end else begin
          st_out = rsp_pkg::STATUS_POOL_FULL;
        end
      end
      rsp_pkg::OP_ADD_REF: begin
        if (hit) begin
          if (cnt_cur == '1) begin
            st_out  = rsp_pkg::STATUS_OVERFLOW;
            cnt_out = cnt_cur;
          end else begin
            st_out   = rsp_pkg::STATUS_OK;
            slot_out = addr;
            cnt_out  = cnt_cur + REF_BITS'(1);
            wdata    = cnt_cur + REF_BITS'(1);
            mem_we   = exec_go;
            nz_set   = exec_go;
          end
        end
      end
      rsp_pkg::OP_RELEASE: begin
        if (hit) begin
          if (cnt_cur == '0) begin
            st_out = rsp_pkg::STATUS_DUPLICATE;
          end else begin
            st_out   = rsp_pkg::STATUS_OK;
            slot_out = addr;
            cnt_out  = cnt_cur - REF_BITS'(1);
            wdata    = cnt_cur - REF_BITS'(1);
            mem_we   = exec_go;
            if (cnt_cur == REF_BITS'(1)) begin
              freed_out = 1'b1;
              nz_clr    = exec_go;
              bump_rel  = exec_go;
            end
          end
        end
      end
      default: begin
        st_out = rsp_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

  // Totals and the peak of reserves minus releases, sampled at each reserve.
  always_comb begin
    reserves_next = bump_res ? reserves_done + 32'd1 : reserves_done;
    releases_next = bump_rel ? releases_done + 32'd1 : releases_done;
    delta         = reserves_next - releases_done;
    peak_next     = (bump_res && (delta > peak_seen)) ? delta : peak_seen;
    cnt_ext       = CE_W'(cnt_out);
    slot_ext      = SE_W'(slot_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nz            <= '0;
      reserves_done <= '0;
      releases_done <= '0;
      peak_seen     <= '0;
    end else begin
      if (nz_set) nz[addr] <= 1'b1;
      if (nz_clr) nz[addr] <= 1'b0;
      reserves_done <= reserves_next;
      releases_done <= releases_next;
      peak_seen     <= peak_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (exec_go) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res.data.status        <= st_out;
      res.data.granted_slot  <= slot_ext[5:0];
      res.data.ref_count     <= cnt_ext[7:0];
      res.data.freed         <= freed_out;
      res.data.reserve_total <= reserves_next;
      res.data.release_total <= releases_next;
      res.data.peak_in_use   <= peak_next;
    end
  end

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req.ready)
    else $error("request accepted while another is in flight");

  // A response appears only out of the modify cycle.
  a_resp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == rsp_pkg::ST_EXEC)
    else $error("response loaded outside the modify cycle");

  // A granted slot is marked in use right after the grant.
  a_grant_marks: assert property (@(posedge clk) disable iff (rst)
    bump_res |=> nz[$past(addr)])
    else $error("granted slot not marked in use");

endmodule
